// ===== rtl/transformed_crop_box_point_filter_assert.svh =====
`ifndef TRANSFORMED_CROP_BOX_POINT_FILTER_ASSERT_SVH
`define TRANSFORMED_CROP_BOX_POINT_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every edge out of reset.
`define TCBPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every edge out of reset.
`define TCBPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcbpf_pkg.sv =====
package tcbpf_pkg;

    localparam int COORD_BITS = 24;
    localparam int TAG_BITS   = 16;
    localparam int ROT_BITS   = 18;
    localparam int ROT_FRAC   = 16;
    localparam int OFS_BITS   = 20;
    localparam int AXES       = 3;

    localparam int ROW_BITS  = AXES * ROT_BITS;
    localparam int SHFT_BITS = AXES * OFS_BITS;
    localparam int BOX_BITS  = 2 * COORD_BITS;

    localparam int CFG_BITS_A = (ROW_BITS > SHFT_BITS) ? ROW_BITS : SHFT_BITS;
    localparam int CFG_BITS   = (CFG_BITS_A > BOX_BITS) ? CFG_BITS_A : BOX_BITS;
    localparam int CFG_IDX_BITS = 3;

    // Transform datapath widths
    localparam int PROD_BITS = ROT_BITS + COORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int SHF_BITS  = SUM_BITS - ROT_FRAC;
    localparam int POS_A     = (SHF_BITS > OFS_BITS) ? SHF_BITS : OFS_BITS;
    localparam int POS_BITS  = ((POS_A > COORD_BITS) ? POS_A : COORD_BITS) + 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_ROW_X     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_ROW_Y     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_ROW_Z     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT_XYZ     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_X         = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Y         = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Z         = 3'd7;

    // Identity entry 1.0 in Q2.16
    localparam logic [ROT_BITS-1:0] ROT_ONE = ROT_BITS'(1 << ROT_FRAC);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic signed [POS_BITS-1:0]   pos_t;
    typedef logic [TAG_BITS-1:0]          tag_t;

endpackage

// ===== rtl/transformed_crop_box_point_filter.sv =====
// Crop-box point filter with a rigid transform in front of the box test. Each
// point is rotated by a Q2.16 matrix (floored by 16 bits), translated, and, when
// filtering is enabled and the point is finite, dropped if it lies inside the
// inclusive box. Kept points come out with their original coordinates; a dropped
// point flagged last_in_cloud comes out as an end marker with keep = 0 and zero
// coordinates; other dropped points produce nothing. One point is accepted per
// cycle while in_stall is low; a result passes through four register stages
// (products, row sums, floor shift and offset, box compare into the output
// register), and every stage, including the nine 18x24 multipliers of the
// first, takes a new item each cycle unless stalled. Stalls back up through
// the stage valid bits without losing or repeating items. Configuration must
// be written only while no point is in flight.
`include "transformed_crop_box_point_filter_assert.svh"

module transformed_crop_box_point_filter (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [tcbpf_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  logic [tcbpf_pkg::CFG_BITS-1:0]              cfg_data,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic signed [tcbpf_pkg::COORD_BITS-1:0]     point_x,
    input  logic signed [tcbpf_pkg::COORD_BITS-1:0]     point_y,
    input  logic signed [tcbpf_pkg::COORD_BITS-1:0]     point_z,
    input  logic                                        coords_finite,
    input  logic [tcbpf_pkg::TAG_BITS-1:0]              point_tag,
    input  logic                                        last_in_cloud,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic                                        keep,
    output logic [tcbpf_pkg::TAG_BITS-1:0]              out_tag,
    output logic signed [tcbpf_pkg::COORD_BITS-1:0]     out_x,
    output logic signed [tcbpf_pkg::COORD_BITS-1:0]     out_y,
    output logic signed [tcbpf_pkg::COORD_BITS-1:0]     out_z,
    output logic                                        cloud_end
);

    localparam int AXES      = tcbpf_pkg::AXES;
    localparam int ROT_BITS  = tcbpf_pkg::ROT_BITS;
    localparam int ROT_FRAC  = tcbpf_pkg::ROT_FRAC;
    localparam int OFS_BITS  = tcbpf_pkg::OFS_BITS;
    localparam int COORD_BITS = tcbpf_pkg::COORD_BITS;
    localparam int SUM_BITS  = tcbpf_pkg::SUM_BITS;
    localparam int POS_BITS  = tcbpf_pkg::POS_BITS;

    // ---------------- configuration registers ----------------
    logic                                  filter_enable_reg;
    logic [tcbpf_pkg::ROW_BITS-1:0]        rot_reg [AXES];
    logic [tcbpf_pkg::SHFT_BITS-1:0]       shift_reg;
    logic [tcbpf_pkg::BOX_BITS-1:0]        box_reg [AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                rot_reg[a] <= tcbpf_pkg::ROW_BITS'(tcbpf_pkg::ROT_ONE) << (a * ROT_BITS);
                box_reg[a] <= '0;
            end
            shift_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcbpf_pkg::CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                tcbpf_pkg::CFG_ROT_ROW_X: rot_reg[0] <= cfg_data[tcbpf_pkg::ROW_BITS-1:0];
                tcbpf_pkg::CFG_ROT_ROW_Y: rot_reg[1] <= cfg_data[tcbpf_pkg::ROW_BITS-1:0];
                tcbpf_pkg::CFG_ROT_ROW_Z: rot_reg[2] <= cfg_data[tcbpf_pkg::ROW_BITS-1:0];
                tcbpf_pkg::CFG_SHIFT_XYZ: shift_reg  <= cfg_data[tcbpf_pkg::SHFT_BITS-1:0];
                tcbpf_pkg::CFG_BOX_X:     box_reg[0] <= cfg_data[tcbpf_pkg::BOX_BITS-1:0];
                tcbpf_pkg::CFG_BOX_Y:     box_reg[1] <= cfg_data[tcbpf_pkg::BOX_BITS-1:0];
                tcbpf_pkg::CFG_BOX_Z:     box_reg[2] <= cfg_data[tcbpf_pkg::BOX_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    logic s1_load, s2_load, s3_load, out_load;
    assign s1_load  = in_valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign s3_load  = s2_valid_reg && s3_ready;
    assign out_load = s3_valid_reg && out_ready;

    // ---------------- stage 1: products ----------------
    tcbpf_pkg::coord_t pt [AXES];
    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    tcbpf_pkg::prod_t  s1_prod_reg [AXES][AXES];
    tcbpf_pkg::coord_t s1_pt_reg [AXES];
    tcbpf_pkg::tag_t   s1_tag_reg;
    logic              s1_chk_reg, s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                for (int c = 0; c < AXES; c++)
                begin
                    s1_prod_reg[a][c] <= $signed(rot_reg[a][c*ROT_BITS +: ROT_BITS]) * pt[c];
                end
                s1_pt_reg[a] <= pt[a];
            end
            s1_tag_reg  <= point_tag;
            s1_chk_reg  <= filter_enable_reg && coords_finite;
            s1_last_reg <= last_in_cloud;
        end
    end

    // ---------------- stage 2: row sums ----------------
    tcbpf_pkg::sum_t   s2_sum_reg [AXES];
    tcbpf_pkg::coord_t s2_pt_reg [AXES];
    tcbpf_pkg::tag_t   s2_tag_reg;
    logic              s2_chk_reg, s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                s2_sum_reg[a] <= SUM_BITS'(s1_prod_reg[a][0]) + SUM_BITS'(s1_prod_reg[a][1])
                               + SUM_BITS'(s1_prod_reg[a][2]);
                s2_pt_reg[a]  <= s1_pt_reg[a];
            end
            s2_tag_reg  <= s1_tag_reg;
            s2_chk_reg  <= s1_chk_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ---------------- stage 3: floor shift and offset ----------------
    tcbpf_pkg::pos_t   s3_pos_reg [AXES];
    tcbpf_pkg::coord_t s3_pt_reg [AXES];
    tcbpf_pkg::tag_t   s3_tag_reg;
    logic              s3_chk_reg, s3_last_reg;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                // dropping the low fraction bits of a two's-complement sum floors it
                s3_pos_reg[a] <= POS_BITS'($signed(s2_sum_reg[a][SUM_BITS-1:ROT_FRAC]))
                               + POS_BITS'($signed(shift_reg[a*OFS_BITS +: OFS_BITS]));
                s3_pt_reg[a]  <= s2_pt_reg[a];
            end
            s3_tag_reg  <= s2_tag_reg;
            s3_chk_reg  <= s2_chk_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------- stage 4: box test into output register ----------------
    logic inside_next, drop_next, out_valid_next;

    always_comb
    begin
        inside_next = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            if (s3_pos_reg[a] < POS_BITS'($signed(box_reg[a][COORD_BITS-1:0])) ||
                s3_pos_reg[a] > POS_BITS'($signed(box_reg[a][2*COORD_BITS-1:COORD_BITS])))
            begin
                inside_next = 1'b0;
            end
        end
        drop_next      = s3_chk_reg && inside_next;
        // drop the result entirely unless it still has to mark the cloud end
        out_valid_next = s3_valid_reg && (!drop_next || s3_last_reg);
    end

    logic              keep_reg, cloud_end_reg;
    tcbpf_pkg::tag_t   out_tag_reg;
    tcbpf_pkg::coord_t out_pt_reg [AXES];

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            keep_reg      <= !drop_next;
            cloud_end_reg <= s3_last_reg;
            out_tag_reg   <= s3_tag_reg;
            for (int a = 0; a < AXES; a++)
            begin
                out_pt_reg[a] <= drop_next ? '0 : s3_pt_reg[a];
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign keep      = keep_reg;
    assign cloud_end = cloud_end_reg;
    assign out_tag   = out_tag_reg;
    assign out_x     = out_pt_reg[0];
    assign out_y     = out_pt_reg[1];
    assign out_z     = out_pt_reg[2];

    // ---------------- assertions ----------------
    `TCBPF_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1_valid_reg,
        "accepted item did not enter stage 1")
    `TCBPF_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s2_ready, s1_valid_reg,
        "stage 1 item lost while downstream was full")
    `TCBPF_ASSERT_NOW(a_marker_is_last, out_valid_reg && !keep_reg, cloud_end_reg,
        "dropped result without cloud end")
    `TCBPF_ASSERT_NOW(a_marker_zeroed, out_valid_reg && !keep_reg,
        out_pt_reg[0] == '0 && out_pt_reg[1] == '0 && out_pt_reg[2] == '0,
        "end marker carries coordinates")

endmodule
